// ===== src/vdg_pixel_color_generator_macros.svh =====
// ----------------------------------------------------------------------------
// vdg_pixel_color_generator_macros
// Assertion macros used by the pixel color generator module.
// ----------------------------------------------------------------------------
`ifndef VDG_PIXEL_COLOR_GENERATOR_MACROS_SVH
`define VDG_PIXEL_COLOR_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VDG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vdg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VDG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vdg assertion failed");

`endif

// ===== src/vdg_pkg.sv =====
// ----------------------------------------------------------------------------
// vdg_pkg
// Types, register indexes and pen constants of the pixel color generator.
// ----------------------------------------------------------------------------
`default_nettype none

package vdg_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COLOR_W    = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE4_SET    = 2'd1;

    localparam logic [2:0] MODE4_SET_MAX = 3'd4;

    typedef logic [2:0] t_pen3;

    // two-bit pixel to pen, one row per mode 4 color set 1 to 4
    localparam t_pen3 [0:3][0:3] PEN_GREEN = '{
        '{3'd0, 3'd1, 3'd6, 3'd2}, '{3'd0, 3'd6, 3'd1, 3'd2},
        '{3'd0, 3'd5, 3'd2, 3'd2}, '{3'd0, 3'd2, 3'd5, 3'd2}
    };
    localparam t_pen3 [0:3][0:3] PEN_WHITE = '{
        '{3'd0, 3'd1, 3'd6, 3'd7}, '{3'd0, 3'd6, 3'd1, 3'd7},
        '{3'd0, 3'd5, 3'd2, 3'd7}, '{3'd0, 3'd2, 3'd5, 3'd7}
    };

    localparam logic [COLOR_W-1:0] PEN_BLACK = 5'd0;
    localparam logic [COLOR_W-1:0] PEN_GREEN_FG = 5'd2;
    localparam logic [COLOR_W-1:0] PEN_WHITE_FG = 5'd7;
    localparam logic [COLOR_W-1:0] PEN_MAX = 5'd19;

    typedef struct packed {
        logic       kind;
        logic [7:0] screen_attr;
        logic [7:0] cell_attr;
        logic [7:0] tile_byte;
        logic [7:0] font_row;
        logic [2:0] pixel_col;
        logic [3:0] pixel_row;
    } t_pix;

    typedef struct packed {
        logic       palette_mode;
        logic [2:0] mode4_set;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/vdg_if.sv =====
// ----------------------------------------------------------------------------
// vdg_if
// Channel interfaces: pixel input, color output, configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdg_pix_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] screen_attr;
    logic [7:0] cell_attr;
    logic [7:0] tile_byte;
    logic [7:0] font_row;
    logic [2:0] pixel_col;
    logic [3:0] pixel_row;

    modport source (output valid, kind, screen_attr, cell_attr, tile_byte, font_row,
                    pixel_col, pixel_row, input ready);
    modport sink (input valid, kind, screen_attr, cell_attr, tile_byte, font_row,
                  pixel_col, pixel_row, output ready);
endinterface

interface vdg_color_if;
    logic                        valid;
    logic                        ready;
    logic [vdg_pkg::COLOR_W-1:0] color_index;

    modport source (output valid, color_index, input ready);
    modport sink (input valid, color_index, output ready);
endinterface

interface vdg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vdg_pkg::CFG_IDX_W-1:0]  index;
    logic [vdg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/vdg_color_logic.sv =====
// ----------------------------------------------------------------------------
// vdg_color_logic
// Mode decode and pen selection for one pixel, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module vdg_color_logic (
    input  vdg_pkg::t_pix                i_pix,
    input  vdg_pkg::t_cfg                i_cfg,
    output logic [vdg_pkg::COLOR_W-1:0]  o_color_index
);

    logic [vdg_pkg::COLOR_W-1:0] border_c, gfx_c, semi_c, text_c;
    logic [2:0] xi;
    logic [2:0] set_c;
    logic [1:0] tbl_row;
    logic [2:0] gsh;
    logic [1:0] gv;
    logic [3:0] yi;
    logic [2:0] sbit;
    logic [2:0] spen;
    logic       lit;
    logic [7:0] sa, ca, tb;

    assign sa = i_pix.screen_attr;
    assign ca = i_pix.cell_attr;
    assign tb = i_pix.tile_byte;
    assign xi = ~i_pix.pixel_col;

    // border
    always_comb begin
        if (!i_cfg.palette_mode || !sa[7]) begin
            border_c = vdg_pkg::PEN_BLACK;
        end else if (!sa[4]) begin
            border_c = {2'b01, sa[1], 2'b00};
        end else begin
            border_c = sa[1] ? vdg_pkg::PEN_WHITE_FG : vdg_pkg::PEN_GREEN_FG;
        end
    end

    // graphics; colour sets above the table clamp to the last row
    assign set_c   = (i_cfg.mode4_set > vdg_pkg::MODE4_SET_MAX) ? vdg_pkg::MODE4_SET_MAX
                                                                : i_cfg.mode4_set;
    assign tbl_row = 2'(set_c - 3'd1);
    assign gsh     = xi & 3'b110;
    assign gv      = 2'(tb >> gsh);

    always_comb begin
        if (!sa[4]) begin
            gfx_c = {2'b01, sa[1], gv};
        end else if (set_c == 3'd0) begin
            if (tb[xi]) begin
                gfx_c = sa[1] ? vdg_pkg::PEN_WHITE_FG : vdg_pkg::PEN_GREEN_FG;
            end else begin
                gfx_c = vdg_pkg::PEN_BLACK;
            end
        end else if (sa[1]) begin
            gfx_c = {2'b00, vdg_pkg::PEN_WHITE[tbl_row][gv]};
        end else begin
            gfx_c = {2'b00, vdg_pkg::PEN_GREEN[tbl_row][gv]};
        end
    end

    // semigraphics; flipped row wraps for rows past the cell
    assign yi = 4'd11 - i_pix.pixel_row;

    always_comb begin
        if (ca[4]) begin
            spen = tb[6:4];
            sbit = {1'b0, (yi >= 4'd6), xi[2]};
        end else begin
            spen = {ca[1], tb[7:6]};
            sbit = {yi[3], yi[2], xi[2]};
        end
        semi_c = tb[sbit] ? {2'b01, spen} : vdg_pkg::PEN_BLACK;
    end

    // text; attribute bit 0 inverts
    assign lit = i_pix.font_row[xi] ^ ca[0];

    always_comb begin
        if (i_cfg.palette_mode) begin
            text_c = {3'b100, ca[1], lit};
        end else if (lit) begin
            text_c = ca[1] ? vdg_pkg::PEN_GREEN_FG : vdg_pkg::PEN_WHITE_FG;
        end else begin
            text_c = vdg_pkg::PEN_BLACK;
        end
    end

    always_comb begin
        if (!i_pix.kind) begin
            o_color_index = border_c;
        end else if (sa[7]) begin
            o_color_index = gfx_c;
        end else if (ca[6]) begin
            o_color_index = semi_c;
        end else begin
            o_color_index = text_c;
        end
    end

endmodule

`default_nettype wire

// ===== src/vdg_pixel_color_generator.sv =====
// ----------------------------------------------------------------------------
// vdg_pixel_color_generator
// Palette pen index for each screen pixel from attributes and pixel data.
// ----------------------------------------------------------------------------
// One pixel per clock, sustained while o_color is ready. A pixel passes an
// input register and then a result register before its pen shows on
// o_color; the color decode between them is one level of mode selection
// plus small constant tables. Each register stage loads whenever
// it is empty or the stage behind it moves, so i_pix.ready stays high while
// the output is taken every cycle and a stalled result holds without losing
// the pixel in the input stage. Configuration writes on i_cfg are always
// ready and take effect on the pixel that is decoded next; index 0 sets
// the palette style (bit 0), index 1 the mode 4 color set (bits 2:0, values
// above 4 act as 4); other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vdg_pixel_color_generator_macros.svh"

module vdg_pixel_color_generator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    vdg_pix_if.sink     i_pix,
    vdg_cfg_if.sink     i_cfg,
    vdg_color_if.source o_color
);

    // configuration registers
    logic       r_palette_mode;
    logic [2:0] r_mode4_set;

    // input stage
    logic          r_pix_valid;
    vdg_pkg::t_pix r_pix;

    // result stage
    logic                        r_out_valid;
    logic [vdg_pkg::COLOR_W-1:0] r_color;

    logic                        out_load;
    logic                        pix_load;
    logic [vdg_pkg::COLOR_W-1:0] n_color;
    vdg_pkg::t_cfg               cfg;
    vdg_pkg::t_pix               pix_in;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_mode <= 1'b1;
            r_mode4_set    <= 3'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                vdg_pkg::REG_PALETTE_MODE: r_palette_mode <= i_cfg.data[0];
                vdg_pkg::REG_MODE4_SET:    r_mode4_set    <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    assign cfg = '{palette_mode: r_palette_mode, mode4_set: r_mode4_set};

    // stage handshakes: a stage loads when empty or when its result leaves
    assign out_load    = !r_out_valid || o_color.ready;
    assign pix_load    = !r_pix_valid || out_load;
    assign i_pix.ready = pix_load;

    assign pix_in = '{
        kind:        i_pix.kind,
        screen_attr: i_pix.screen_attr,
        cell_attr:   i_pix.cell_attr,
        tile_byte:   i_pix.tile_byte,
        font_row:    i_pix.font_row,
        pixel_col:   i_pix.pixel_col,
        pixel_row:   i_pix.pixel_row
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (pix_load) begin
            r_pix_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_load && i_pix.valid) begin
            r_pix <= pix_in;
        end
    end

    vdg_color_logic u_color (
        .i_pix         (r_pix),
        .i_cfg         (cfg),
        .o_color_index (n_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_pix_valid) begin
            r_color <= n_color;
        end
    end

    assign o_color.valid       = r_out_valid;
    assign o_color.color_index = r_color;

    // an accepted pixel lands in the input stage
    `VDG_ASSERT_NEXT(a_pix_lands, i_clk, i_rst_n, i_pix.valid && i_pix.ready, r_pix_valid)
    // a pixel moving out of the input stage becomes a visible result
    `VDG_ASSERT_NEXT(a_pix_moves, i_clk, i_rst_n, r_pix_valid && out_load, o_color.valid)
    // pens stay inside the palette
    `VDG_ASSERT_IMPL(a_pen_range, i_clk, i_rst_n, o_color.valid,
        o_color.color_index <= vdg_pkg::PEN_MAX)

endmodule

`default_nettype wire
